// ===== sv/mcpwc_pkg.sv =====
// shared types and constants for the multi-channel pulse width capture block
// used by mcpwc_ctrl, mcpwc_dp and the top level; no dependencies
`timescale 1ns / 1ps

package mcpwc_pkg;

    // default sizing, handed down through the top level parameters
    localparam int unsigned DEF_NUM_CHANNELS = 7;
    localparam int unsigned DEF_TIME_BITS    = 32;

    // field widths of the stream payloads
    localparam int unsigned PIN_BITS      = 16;
    localparam int unsigned STAMP_BITS    = 32;
    localparam int unsigned CHAN_BITS     = 4;
    localparam int unsigned WIDTH_BITS    = 32;
    localparam int unsigned S_TDATA_BITS  = 48;
    localparam int unsigned M_TDATA_BITS  = 56;

    // channel to pin bit map; channels past the map have no pin
    localparam int unsigned MAPPED_CHANNELS = 7;
    localparam int unsigned PIN_MAP [MAPPED_CHANNELS] = '{5, 3, 1, 2, 0, 6, 4};

    // request kind carried on tuser
    typedef enum logic {
        FUNC_SAMPLE = 1'b0,
        FUNC_READ   = 1'b1
    } func_t;

    // controller states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic sample_en;
        logic idx_clear;
        logic load_en;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
        logic idx_last;
    } sts_t;

endpackage

// ===== sv/mcpwc_ctrl.sv =====
// controller state machine: accepts requests and sequences the per-channel readout
// depends on mcpwc_pkg
`timescale 1ns / 1ps

module mcpwc_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  mcpwc_pkg::func_t  func,
    input  mcpwc_pkg::sts_t   sts,
    output mcpwc_pkg::cmd_t   cmd
);
    import mcpwc_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && func == FUNC_READ)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (sts.out_free && sts.idx_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready      = 1'b1;
                cmd.sample_en = s_tvalid && func == FUNC_SAMPLE;
                cmd.idx_clear = s_tvalid && func == FUNC_READ;
            end
            ST_READ:
            begin
                cmd.load_en = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

`ifndef SYNTHESIS
    // a result is only loaded when the output register can take it
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_en |-> sts.out_free)
        else $error("load while output register busy");

    // no sampling while a readout is in progress
    a_no_sample_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sample_en |-> !cmd.load_en && state_reg == ST_IDLE)
        else $error("sample during readout");

    // loading the final channel ends the readout
    a_read_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_en && sts.idx_last) |=> state_reg == ST_IDLE)
        else $error("readout did not end after final channel");

    // a read request starts the readout on the next cycle
    a_read_starts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.idx_clear |=> state_reg == ST_READ)
        else $error("read request did not start readout");
`endif

endmodule

// ===== sv/mcpwc_dp.sv =====
// datapath: per-channel edge capture, width store, readout index and output register
// depends on mcpwc_pkg
`timescale 1ns / 1ps

module mcpwc_dp
#(
    parameter int unsigned NUM_CHANNELS = mcpwc_pkg::DEF_NUM_CHANNELS,
    parameter int unsigned TIME_BITS    = mcpwc_pkg::DEF_TIME_BITS
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  mcpwc_pkg::cmd_t                    cmd,
    output mcpwc_pkg::sts_t                    sts,
    input  logic [mcpwc_pkg::PIN_BITS-1:0]     pin_word,
    input  logic [mcpwc_pkg::STAMP_BITS-1:0]   timestamp,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [mcpwc_pkg::CHAN_BITS-1:0]    channel,
    output logic [mcpwc_pkg::WIDTH_BITS-1:0]   high_width,
    output logic [mcpwc_pkg::PIN_BITS-1:0]     pin_snapshot,
    output logic                               last
);
    import mcpwc_pkg::*;

    localparam int unsigned IDX_BITS = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic [NUM_CHANNELS-1:0]  pin_hi;
    logic [TIME_BITS-1:0]     now;

    logic [NUM_CHANNELS-1:0]  low_flag_reg;
    logic [NUM_CHANNELS-1:0]  low_flag_next;
    logic [TIME_BITS-1:0]     rise_reg   [NUM_CHANNELS];
    logic [TIME_BITS-1:0]     rise_next  [NUM_CHANNELS];
    logic [TIME_BITS-1:0]     width_reg  [NUM_CHANNELS];
    logic [TIME_BITS-1:0]     width_next [NUM_CHANNELS];
    logic [PIN_BITS-1:0]      pins_reg;
    logic [PIN_BITS-1:0]      pins_next;

    logic [IDX_BITS-1:0]      idx_reg;
    logic [IDX_BITS-1:0]      idx_next;

    logic                     valid_reg;
    logic                     valid_next;
    logic [CHAN_BITS-1:0]     chan_reg;
    logic [WIDTH_BITS-1:0]    hw_reg;
    logic [PIN_BITS-1:0]      snap_reg;
    logic                     last_reg;

    assign now = TIME_BITS'(timestamp);

    // pin level seen by each channel
    for (genvar ch = 0; ch < NUM_CHANNELS; ch++)
    begin : g_pin
        if (ch < MAPPED_CHANNELS)
        begin : g_mapped
            assign pin_hi[ch] = pin_word[PIN_MAP[ch]];
        end
        else
        begin : g_unmapped
            assign pin_hi[ch] = 1'b0;
        end
    end

    // edge detection and capture, all channels in parallel
    always_comb
    begin
        low_flag_next = low_flag_reg;
        pins_next     = pins_reg;
        for (int ch = 0; ch < NUM_CHANNELS; ch++)
        begin
            rise_next[ch]  = rise_reg[ch];
            width_next[ch] = width_reg[ch];
            if (cmd.sample_en)
            begin
                if (!pin_hi[ch])
                begin
                    // falling edge: width from stored rise time
                    if (!low_flag_reg[ch])
                    begin
                        width_next[ch] = now - rise_reg[ch];
                    end
                    low_flag_next[ch] = 1'b1;
                end
                else
                begin
                    // rising edge: remember the time
                    if (low_flag_reg[ch])
                    begin
                        rise_next[ch] = now;
                    end
                    low_flag_next[ch] = 1'b0;
                end
            end
        end
        if (cmd.sample_en)
        begin
            pins_next = pin_word;
        end
    end

    // capture state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_flag_reg <= '0;
            pins_reg     <= '0;
            for (int ch = 0; ch < NUM_CHANNELS; ch++)
            begin
                rise_reg[ch]  <= '0;
                width_reg[ch] <= '0;
            end
        end
        else
        begin
            low_flag_reg <= low_flag_next;
            pins_reg     <= pins_next;
            for (int ch = 0; ch < NUM_CHANNELS; ch++)
            begin
                rise_reg[ch]  <= rise_next[ch];
                width_reg[ch] <= width_next[ch];
            end
        end
    end

    // readout channel index, back to channel 0 after the final channel
    always_comb
    begin
        priority if (cmd.idx_clear)
        begin
            idx_next = '0;
        end
        else if (cmd.load_en && sts.idx_last)
        begin
            idx_next = '0;
        end
        else if (cmd.load_en)
        begin
            idx_next = idx_reg + 1'b1;
        end
        else
        begin
            idx_next = idx_reg;
        end
    end

    // output register handshake
    always_comb
    begin
        priority if (cmd.load_en)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // output payload, loaded one channel per request slot
    always_ff @(posedge clk)
    begin
        if (cmd.load_en)
        begin
            chan_reg <= CHAN_BITS'(idx_reg);
            hw_reg   <= WIDTH_BITS'(width_reg[idx_reg]);
            snap_reg <= pins_reg;
            last_reg <= sts.idx_last;
        end
    end

    assign sts.out_free = !valid_reg || out_ready;
    assign sts.idx_last = idx_reg == IDX_BITS'(NUM_CHANNELS - 1);

    assign out_valid    = valid_reg;
    assign channel      = chan_reg;
    assign high_width   = hw_reg;
    assign pin_snapshot = snap_reg;
    assign last         = last_reg;

`ifndef SYNTHESIS
    // readout index never runs past the channel count
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= IDX_BITS'(NUM_CHANNELS - 1))
        else $error("readout index out of range");

    // a loaded result is presented on the next cycle
    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_en |=> valid_reg)
        else $error("loaded result not presented");

    // the pin snapshot and level flags do not change while a readout loads results
    a_hold_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_en |=> $stable(pins_reg) && $stable(low_flag_reg))
        else $error("capture state changed during readout");
`endif

endmodule

// ===== sv/multi_channel_pulse_width_capture_core.sv =====
// top level of the multi-channel pulse width capture block
// depends on mcpwc_pkg, mcpwc_ctrl and mcpwc_dp
`timescale 1ns / 1ps

// Measures the high time of up to seven pulse channels taken from fixed pin bits.
// Input stream (s_*): each request is either a pin sample (tuser = 0) carrying the
// pin word and a free-running timestamp, or a readout request (tuser = 1).
// A sample produces no result; samples may arrive
// back to back, one per clock, while the block is idle.
// A readout produces NUM_CHANNELS results on the output stream (m_*), channel 0
// first, each with its last high time, the latest pin word and tlast on the
// final channel. The readout walks the stored widths one channel per cycle while
// the output register is free to take each result; the input is held off
// (s_tready low) during that walk.
// A single output register sits between the sides: while it holds an untaken
// result, the next sample can still be accepted, and a receiver stall pauses
// the readout walk without losing or repeating a channel.
// Reset clears all level flags, rise times, widths and the pin snapshot, and
// empties the output register; the block is ready as soon as reset is released.
module multi_channel_pulse_width_capture_core
#(
    parameter int unsigned NUM_CHANNELS = mcpwc_pkg::DEF_NUM_CHANNELS,
    parameter int unsigned TIME_BITS    = mcpwc_pkg::DEF_TIME_BITS
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [mcpwc_pkg::S_TDATA_BITS-1:0]   s_tdata,  // pin_word, timestamp
    input  logic                                 s_tuser,  // func
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [mcpwc_pkg::M_TDATA_BITS-1:0]   m_tdata,  // channel, high_width, pin_snapshot, pad
    output logic                                 m_tlast
);
    import mcpwc_pkg::*;

    cmd_t                    cmd;
    sts_t                    sts;
    func_t                   func;
    logic [CHAN_BITS-1:0]    channel;
    logic [WIDTH_BITS-1:0]   high_width;
    logic [PIN_BITS-1:0]     pin_snapshot;

    assign func = func_t'(s_tuser);

    // controller
    mcpwc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .func     (func),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath
    mcpwc_dp
    #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .TIME_BITS    (TIME_BITS)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .pin_word     (s_tdata[PIN_BITS-1:0]),
        .timestamp    (s_tdata[PIN_BITS +: STAMP_BITS]),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .channel      (channel),
        .high_width   (high_width),
        .pin_snapshot (pin_snapshot),
        .last         (m_tlast)
    );

    // result packing, padded to whole bytes
    assign m_tdata = {4'b0000, pin_snapshot, high_width, channel};

endmodule
